// ===== hdl/eot_hdr_pkg.sv =====
// shared types and constants for the embedded opentype header parser
package eot_hdr_pkg;

  localparam logic [15:0] MAGIC_WORD      = 16'h504C;
  localparam logic [31:0] TRAILER_VERSION = 32'h0002_0002;
  localparam logic [31:0] FIXED_LEN       = 32'd82;
  localparam logic [31:0] OFFSET_MAX      = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    PH_FIXED,
    PH_LEN,
    PH_STR,
    PH_PAD,
    PH_CSUM,
    PH_CPAGE,
    PH_PAD6,
    PH_SIGLEN,
    PH_SIG,
    PH_EFLAGS,
    PH_ESIZE,
    PH_EUDC,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNC,
    ST_MAGIC,
    ST_PAD,
    ST_ODD,
    ST_SIZE
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] parsed_len;
    logic [31:0] total_size;
    logic [31:0] font_len;
    logic [31:0] format_version;
    logic [31:0] header_flags;
    logic [7:0]  char_set;
    logic [7:0]  italic_flag;
    logic [31:0] font_weight;
    logic [15:0] embed_type;
    logic [31:0] root_checksum;
    logic [31:0] eudc_cpage;
  } result_t;

endpackage

// ===== hdl/eot_hdr_if.sv =====
// byte input and result channel interfaces
interface eot_hdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface eot_hdr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] parsed_len;
  logic [31:0] total_size;
  logic [31:0] font_len;
  logic [31:0] format_version;
  logic [31:0] header_flags;
  logic [7:0]  char_set;
  logic [7:0]  italic_flag;
  logic [31:0] font_weight;
  logic [15:0] embed_type;
  logic [31:0] root_checksum;
  logic [31:0] eudc_cpage;

  modport source (
    output valid, status, parsed_len, total_size, font_len, format_version,
           header_flags, char_set, italic_flag, font_weight, embed_type, root_checksum,
           eudc_cpage,
    input ready
  );
  modport sink (
    input valid, status, parsed_len, total_size, font_len, format_version,
          header_flags, char_set, italic_flag, font_weight, embed_type, root_checksum,
          eudc_cpage,
    output ready
  );
endinterface

// ===== hdl/eot_hdr_in_reg.sv =====
// input register stage for byte beats
module eot_hdr_in_reg import eot_hdr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  eot_hdr_in_if.sink     in_bus,
  input  logic           take,
  output logic           beat_valid,
  output beat_t          beat
);

  logic  valid_r;
  logic  valid_nxt;
  beat_t beat_r;
  logic  load;

  assign in_bus.ready = !valid_r || take;
  assign load         = in_bus.valid && in_bus.ready;
  assign valid_nxt    = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= '{data_byte: in_bus.data_byte, last_byte: in_bus.last_byte};
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

// ===== hdl/eot_hdr_parser.sv =====
// parse phase machine, held header fields and result formation
module eot_hdr_parser import eot_hdr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    beat_valid,
  input  beat_t   beat,
  input  logic    out_space,
  output logic    take,
  output result_t result
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [2:0]  shift_r, shift_nxt;
  logic [2:0]  sidx_r, sidx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] version_r, version_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [31:0] weight_r, weight_nxt;
  logic [7:0]  charset_r, charset_nxt;
  logic [7:0]  italic_r, italic_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] magic_r, magic_nxt;
  logic [31:0] csum_r, csum_nxt;
  logic [31:0] cpage_r, cpage_nxt;
  status_t     status_r, status_nxt;
  logic        done_r, done_nxt;

  logic [31:0] off_inc;
  logic [31:0] left_dec;
  logic [31:0] acc_new;
  logic [6:0]  pos;
  logic [32:0] size_diff;
  logic        size_bad;
  logic        str_close;
  logic        finish;
  logic [7:0]  b;

  function automatic logic [31:0] set_lane(logic [31:0] v, logic [1:0] lane, logic [7:0] d);
    return v | ({24'd0, d} << {lane, 3'b000});
  endfunction

  assign take = beat_valid && (!beat.last_byte || out_space);
  assign b    = beat.data_byte;

  assign off_inc   = offset_r + 32'd1;
  assign left_dec  = left_r - {31'd0, (left_r != 32'd0)};
  assign pos       = offset_r[6:0];
  assign size_diff = {1'b0, total_r} - {1'b0, dsize_r};
  assign size_bad  = size_diff[32] || (size_diff[31:0] != off_inc);

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    offset_nxt  = offset_r;
    shift_nxt   = shift_r;
    sidx_nxt    = sidx_r;
    acc_nxt     = acc_r;
    total_nxt   = total_r;
    dsize_nxt   = dsize_r;
    version_nxt = version_r;
    flags_nxt   = flags_r;
    weight_nxt  = weight_r;
    charset_nxt = charset_r;
    italic_nxt  = italic_r;
    type_nxt    = type_r;
    magic_nxt   = magic_r;
    csum_nxt    = csum_r;
    cpage_nxt   = cpage_r;
    status_nxt  = status_r;
    done_nxt    = done_r;
    acc_new     = acc_r;
    str_close   = 1'b0;
    finish      = 1'b0;

    if (phase_r != PH_DONE && phase_r != PH_FAIL) begin
      if (offset_r == OFFSET_MAX) begin
        // offset counter saturated
        status_nxt = ST_SIZE;
        phase_nxt  = PH_FAIL;
      end else begin
        offset_nxt = off_inc;
        if (phase_r == PH_FIXED) begin
          if (pos < 7'd4) begin
            total_nxt = set_lane(total_r, pos[1:0], b);
          end else if (pos < 7'd8) begin
            dsize_nxt = set_lane(dsize_r, pos[1:0], b);
          end else if (pos < 7'd12) begin
            version_nxt = set_lane(version_r, pos[1:0], b);
          end else if (pos < 7'd16) begin
            flags_nxt = set_lane(flags_r, pos[1:0], b);
          end else if (pos == 7'd26) begin
            charset_nxt = b;
          end else if (pos == 7'd27) begin
            italic_nxt = b;
          end else if (pos >= 7'd28 && pos < 7'd32) begin
            weight_nxt = set_lane(weight_r, pos[1:0], b);
          end else if (pos == 7'd32 || pos == 7'd33) begin
            type_nxt = 16'(set_lane({16'd0, type_r}, {1'b0, pos[0]}, b));
          end else if (pos == 7'd34 || pos == 7'd35) begin
            magic_nxt = 16'(set_lane({16'd0, magic_r}, {1'b0, pos[0]}, b));
          end
          if (off_inc == FIXED_LEN) begin
            if (magic_r != MAGIC_WORD) begin
              status_nxt = ST_MAGIC;
              phase_nxt  = PH_FAIL;
            end else begin
              sidx_nxt  = 3'd0;
              phase_nxt = PH_LEN;
              left_nxt  = 32'd2;
              shift_nxt = 3'd0;
              acc_nxt   = 32'd0;
            end
          end
        end else begin
          // skipped bodies do not collect bytes
          if (phase_r != PH_STR && phase_r != PH_SIG && phase_r != PH_EUDC &&
              shift_r < 3'd4) begin
            acc_new   = set_lane(acc_r, shift_r[1:0], b);
            shift_nxt = shift_r + 3'd1;
          end
          acc_nxt  = acc_new;
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            shift_nxt = 3'd0;
            acc_nxt   = 32'd0;
            unique case (phase_r)
              PH_LEN: begin
                if (acc_new[0]) begin
                  status_nxt = ST_ODD;
                  phase_nxt  = PH_FAIL;
                end else if (acc_new != 32'd0) begin
                  phase_nxt = PH_STR;
                  left_nxt  = acc_new;
                end else begin
                  str_close = 1'b1;
                end
              end
              PH_STR: str_close = 1'b1;
              PH_PAD: begin
                if (acc_new != 32'd0) begin
                  status_nxt = ST_PAD;
                  phase_nxt  = PH_FAIL;
                end else begin
                  sidx_nxt  = sidx_r + 3'd1;
                  phase_nxt = PH_LEN;
                  left_nxt  = 32'd2;
                end
              end
              PH_CSUM: begin
                csum_nxt  = acc_new;
                phase_nxt = PH_CPAGE;
                left_nxt  = 32'd4;
              end
              PH_CPAGE: begin
                cpage_nxt = acc_new;
                phase_nxt = PH_PAD6;
                left_nxt  = 32'd2;
              end
              PH_PAD6: begin
                if (acc_new != 32'd0) begin
                  status_nxt = ST_PAD;
                  phase_nxt  = PH_FAIL;
                end else begin
                  phase_nxt = PH_SIGLEN;
                  left_nxt  = 32'd2;
                end
              end
              PH_SIGLEN: begin
                if (acc_new != 32'd0) begin
                  phase_nxt = PH_SIG;
                  left_nxt  = acc_new;
                end else begin
                  phase_nxt = PH_EFLAGS;
                  left_nxt  = 32'd4;
                end
              end
              PH_SIG: begin
                phase_nxt = PH_EFLAGS;
                left_nxt  = 32'd4;
              end
              PH_EFLAGS: begin
                phase_nxt = PH_ESIZE;
                left_nxt  = 32'd4;
              end
              PH_ESIZE: begin
                if (acc_new != 32'd0) begin
                  phase_nxt = PH_EUDC;
                  left_nxt  = acc_new;
                end else begin
                  finish = 1'b1;
                end
              end
              PH_EUDC: finish = 1'b1;
              default: ;
            endcase
          end
        end
      end
    end

    // a string closes after its last byte, an empty one at once
    if (str_close) begin
      if (sidx_r[2]) begin
        if (version_r == TRAILER_VERSION) begin
          phase_nxt = PH_CSUM;
          left_nxt  = 32'd4;
        end else begin
          finish = 1'b1;
        end
      end else begin
        phase_nxt = PH_PAD;
        left_nxt  = 32'd2;
      end
    end

    if (finish) begin
      done_nxt  = 1'b1;
      phase_nxt = PH_DONE;
      if (size_bad) begin
        status_nxt = ST_SIZE;
      end
    end
  end

  always_comb begin
    result.status         = (status_nxt == ST_OK && !done_nxt) ? ST_TRUNC : status_nxt;
    result.parsed_len     = done_nxt ? offset_nxt : 32'd0;
    result.total_size     = total_nxt;
    result.font_len       = dsize_nxt;
    result.format_version = version_nxt;
    result.header_flags   = flags_nxt;
    result.char_set       = charset_nxt;
    result.italic_flag    = italic_nxt;
    result.font_weight    = weight_nxt;
    result.embed_type     = type_nxt;
    result.root_checksum  = csum_nxt;
    result.eudc_cpage     = cpage_nxt;
  end

  // the last beat of a file returns everything to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (take && beat.last_byte)) begin
      phase_r   <= PH_FIXED;
      left_r    <= 32'd0;
      offset_r  <= 32'd0;
      shift_r   <= 3'd0;
      sidx_r    <= 3'd0;
      acc_r     <= 32'd0;
      total_r   <= 32'd0;
      dsize_r   <= 32'd0;
      version_r <= 32'd0;
      flags_r   <= 32'd0;
      weight_r  <= 32'd0;
      charset_r <= 8'd0;
      italic_r  <= 8'd0;
      type_r    <= 16'd0;
      magic_r   <= 16'd0;
      csum_r    <= 32'd0;
      cpage_r   <= 32'd0;
      status_r  <= ST_OK;
      done_r    <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      offset_r  <= offset_nxt;
      shift_r   <= shift_nxt;
      sidx_r    <= sidx_nxt;
      acc_r     <= acc_nxt;
      total_r   <= total_nxt;
      dsize_r   <= dsize_nxt;
      version_r <= version_nxt;
      flags_r   <= flags_nxt;
      weight_r  <= weight_nxt;
      charset_r <= charset_nxt;
      italic_r  <= italic_nxt;
      type_r    <= type_nxt;
      magic_r   <= magic_nxt;
      csum_r    <= csum_nxt;
      cpage_r   <= cpage_nxt;
      status_r  <= status_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

// ===== hdl/eot_hdr_out_reg.sv =====
// result output register
module eot_hdr_out_reg import eot_hdr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  result_t       result,
  output logic          out_space,
  eot_hdr_out_if.source out_bus
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_space = !valid_r || out_bus.ready;
  assign valid_nxt = load || (valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_bus.valid          = valid_r;
  assign out_bus.status         = res_r.status;
  assign out_bus.parsed_len     = res_r.parsed_len;
  assign out_bus.total_size     = res_r.total_size;
  assign out_bus.font_len       = res_r.font_len;
  assign out_bus.format_version = res_r.format_version;
  assign out_bus.header_flags   = res_r.header_flags;
  assign out_bus.char_set       = res_r.char_set;
  assign out_bus.italic_flag    = res_r.italic_flag;
  assign out_bus.font_weight    = res_r.font_weight;
  assign out_bus.embed_type     = res_r.embed_type;
  assign out_bus.root_checksum  = res_r.root_checksum;
  assign out_bus.eudc_cpage     = res_r.eudc_cpage;

endmodule

// ===== hdl/eot_header_stream_parser_unit.sv =====
// top level of the embedded opentype header stream parser
//
//   channel   dir  payload                                    handshake
//   in_bus    in   data_byte, last_byte                       valid / ready
//   out_bus   out  status, parsed_len, header fields          valid / ready
//
// one byte beat per cycle while the output register has space for each last beat
// the per-byte work is one pass of the phase machine in eot_hdr_parser, between
// the input register and the output register
// synchronous active-low reset puts the parser in the fixed header phase, all fields zero
// only a last beat waits on a full output register; the beats behind it wait with it
// after each last beat the parser returns to its reset state for the next file
module eot_header_stream_parser_unit import eot_hdr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  eot_hdr_in_if.sink    in_bus,
  eot_hdr_out_if.source out_bus
);

  // beat from the input register and its handoff to the parser
  logic    beat_valid;
  beat_t   beat;
  logic    take;

  // space in the output register for a finished result
  logic    out_space;
  result_t result;

  // input register: takes a new beat when it is empty or the held one moves on
  eot_hdr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // phase machine and held fields, one byte per pass
  eot_hdr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .out_space  (out_space),
    .take       (take),
    .result     (result)
  );

  // result register, loaded only by a last beat
  eot_hdr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && beat.last_byte),
    .result    (result),
    .out_space (out_space),
    .out_bus   (out_bus)
  );

endmodule
